[rtl/cllm_pkg.sv]
// Shared constants, types and helpers for the cursor linked list manager.
package cllm_pkg;

    localparam int NODES      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = $clog2(NODES);

    // Fixed field widths of the stream words
    localparam int MODE_W  = 2;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;

    localparam int S_TDATA_W = ((MODE_W + POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + VALUE_W + SLOT_W + 7) / 8) * 8;

    localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(NODES - 1);
    localparam logic [SLOT_W-1:0] NULL_SLOT = '0;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value_in;
    } cmd_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } link_req_t;

    typedef struct packed {
        logic                  we;
        logic [SLOT_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [SLOT_W-1:0]     raddr;
    } val_req_t;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] value_out;
        logic [SLOT_W-1:0]  slot_found;
    } result_t;

    // Cursor held by a slot that has never been written: free chain
    // 1 -> 2 -> ... -> NODES-2 -> end, list head empty.
    function automatic logic [SLOT_W-1:0] link_init(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] nxt;
        nxt = (slot < SLOT_W'(NODES - 2)) ? slot + 1'b1 : NULL_SLOT;
        return nxt;
    endfunction

endpackage

[rtl/cursor_linked_list_manager.sv]
// Cursor linked list manager: one ordered value list plus a free chain in slot memories.
//
// Requests arrive on the s_ stream, one word per request: insert a value at a
// list position, delete the node at a position, or find the first slot that
// holds a value. Each request gives exactly one result word on the m_ stream.
// One request is worked on at a time; s_tready is high only while idle.
// The cursor walk does one read of the link memory per cycle, the next
// address taken straight from the registered read data. Patching links
// takes one link memory write at a time (one write port).
// A result sits in the output register until taken; the block may accept and
// work the next request meanwhile, and holds its result until that register
// frees up. Reset empties the list and rebuilds the free chain at once
// (per-slot valid bits stand in for the initial cursors), no clearing pass.
module cursor_linked_list_manager (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cllm_pkg::S_TDATA_W-1:0] s_tdata,  // mode, position, value_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cllm_pkg::M_TDATA_W-1:0] m_tdata   // status, value_out, slot_found
);

    localparam int POS_LO = cllm_pkg::MODE_W;
    localparam int VAL_LO = cllm_pkg::MODE_W + cllm_pkg::POS_W;

    cllm_pkg::cmd_t                  cmd;
    cllm_pkg::link_req_t             link_req;
    cllm_pkg::val_req_t              val_req;
    logic [cllm_pkg::SLOT_W-1:0]     link_rdata;
    logic [cllm_pkg::DATA_WIDTH-1:0] val_rdata;
    logic                            res_valid;
    logic                            res_ready;
    cllm_pkg::result_t               res;
    logic                            m_tvalid_reg;
    cllm_pkg::result_t               out_reg;

    assign cmd.mode     = s_tdata[cllm_pkg::MODE_W-1:0];
    assign cmd.position = s_tdata[POS_LO +: cllm_pkg::POS_W];
    assign cmd.value_in = s_tdata[VAL_LO +: cllm_pkg::VALUE_W];

    cllm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (cmd),
        .link_req   (link_req),
        .link_rdata (link_rdata),
        .val_req    (val_req),
        .val_rdata  (val_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    cllm_link_ram u_link_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (link_req),
        .rdata   (link_rdata)
    );

    cllm_value_ram u_value_ram (
        .aclk  (aclk),
        .req   (val_req),
        .rdata (val_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = cllm_pkg::M_TDATA_W'({out_reg.slot_found, out_reg.value_out,
                                            out_reg.status});

endmodule

[rtl/cllm_link_ram.sv]
// Cursor store: one write and one registered read port, per-slot valid bits.
module cllm_link_ram (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cllm_pkg::link_req_t         req,
    output logic [cllm_pkg::SLOT_W-1:0] rdata
);

    logic [cllm_pkg::SLOT_W-1:0] mem [cllm_pkg::NODES];
    logic [cllm_pkg::NODES-1:0]  valid_reg;
    logic [cllm_pkg::SLOT_W-1:0] rdata_reg;
    logic [cllm_pkg::SLOT_W-1:0] raddr_reg;
    logic                        rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
        raddr_reg <= req.raddr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            rvalid_reg <= valid_reg[req.raddr];
            if (req.we) begin
                valid_reg[req.waddr] <= 1'b1;
            end
        end
    end

    // unwritten slots read as their reset cursor
    assign rdata = rvalid_reg ? rdata_reg : cllm_pkg::link_init(raddr_reg);

endmodule

[rtl/cllm_value_ram.sv]
// Value store: one write and one registered read port, no reset contents.
module cllm_value_ram (
    input  logic                            aclk,
    input  cllm_pkg::val_req_t              req,
    output logic [cllm_pkg::DATA_WIDTH-1:0] rdata
);

    logic [cllm_pkg::DATA_WIDTH-1:0] mem [cllm_pkg::NODES];
    logic [cllm_pkg::DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/cllm_ctrl.sv]
// Sequencer: walks the cursor chain one link per cycle and patches links.
module cllm_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cllm_pkg::cmd_t                  cmd,
    output cllm_pkg::link_req_t             link_req,
    input  logic [cllm_pkg::SLOT_W-1:0]     link_rdata,
    output cllm_pkg::val_req_t              val_req,
    input  logic [cllm_pkg::DATA_WIDTH-1:0] val_rdata,
    output logic                            res_valid,
    input  logic                            res_ready,
    output cllm_pkg::result_t               res
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_WALK = 7'b0000010,
        ST_FIND = 7'b0000100,
        ST_INS  = 7'b0001000,
        ST_DEL1 = 7'b0010000,
        ST_DEL2 = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [cllm_pkg::SLOT_W-1:0]     cur_reg, cur_next;       // node being walked
    logic [cllm_pkg::POS_W-1:0]      cnt_reg, cnt_next;       // links still to follow
    logic [cllm_pkg::SLOT_W-1:0]     nj_reg, nj_next;         // successor / victim slot
    logic [cllm_pkg::SLOT_W-1:0]     free_reg, free_next;     // free chain head
    logic [cllm_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [cllm_pkg::DATA_WIDTH-1:0] val_reg, val_next;
    cllm_pkg::result_t               res_reg, res_next;

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        nj_next    = nj_reg;
        free_next  = free_reg;
        mode_next  = mode_reg;
        val_next   = val_reg;
        res_next   = res_reg;
        link_req   = '0;
        link_req.raddr = cur_reg;
        val_req    = '0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                link_req.raddr = cllm_pkg::HEAD_SLOT;
                if (in_valid) begin
                    mode_next = cmd.mode;
                    val_next  = cllm_pkg::DATA_WIDTH'(cmd.value_in);
                    cur_next  = cllm_pkg::HEAD_SLOT;
                    cnt_next  = cmd.position - 1'b1;
                    res_next.status     = 1'b1;
                    res_next.value_out  = '0;
                    res_next.slot_found = cllm_pkg::NULL_SLOT;
                    case (cmd.mode) inside
                        cllm_pkg::MODE_INSERT, cllm_pkg::MODE_DELETE: begin
                            state_next = (cmd.position == '0) ? ST_DONE : ST_WALK;
                        end
                        cllm_pkg::MODE_FIND: begin
                            state_next = ST_FIND;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // link_rdata is the cursor of cur_reg
                if (cnt_reg != '0) begin
                    if (link_rdata == cllm_pkg::NULL_SLOT) begin
                        state_next = ST_DONE;
                    end else begin
                        cur_next       = link_rdata;
                        cnt_next       = cnt_reg - 1'b1;
                        link_req.raddr = link_rdata;
                    end
                end else if (mode_reg == cllm_pkg::MODE_INSERT) begin
                    if (free_reg == cllm_pkg::NULL_SLOT) begin
                        state_next = ST_DONE;
                    end else begin
                        link_req.raddr = free_reg;
                        link_req.we    = 1'b1;
                        link_req.waddr = cur_reg;
                        link_req.wdata = free_reg;
                        val_req.we     = 1'b1;
                        val_req.waddr  = free_reg;
                        val_req.wdata  = val_reg;
                        nj_next        = link_rdata;
                        state_next     = ST_INS;
                    end
                end else begin
                    if (link_rdata == cllm_pkg::NULL_SLOT) begin
                        state_next = ST_DONE;
                    end else begin
                        link_req.raddr = link_rdata;
                        nj_next        = link_rdata;
                        state_next     = ST_DEL1;
                    end
                end
            end
            ST_INS: begin
                free_next       = link_rdata;
                link_req.we     = 1'b1;
                link_req.waddr  = free_reg;
                link_req.wdata  = nj_reg;
                res_next.status = 1'b0;
                state_next      = ST_DONE;
            end
            ST_DEL1: begin
                // unlink the victim: predecessor takes its cursor
                link_req.we        = 1'b1;
                link_req.waddr     = cur_reg;
                link_req.wdata     = link_rdata;
                res_next.value_out = cllm_pkg::VALUE_W'(val_rdata);
                res_next.status    = 1'b0;
                state_next         = ST_DEL2;
            end
            ST_DEL2: begin
                link_req.we    = 1'b1;
                link_req.waddr = nj_reg;
                link_req.wdata = free_reg;
                free_next      = nj_reg;
                state_next     = ST_DONE;
            end
            ST_FIND: begin
                if (cur_reg != cllm_pkg::HEAD_SLOT && val_rdata == val_reg) begin
                    res_next.status     = 1'b0;
                    res_next.slot_found = cur_reg;
                    state_next          = ST_DONE;
                end else if (link_rdata == cllm_pkg::NULL_SLOT) begin
                    state_next = ST_DONE;
                end else begin
                    cur_next       = link_rdata;
                    link_req.raddr = link_rdata;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        val_req.raddr = link_req.raddr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            free_reg  <= cllm_pkg::SLOT_W'(1);
        end else begin
            state_reg <= state_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        cnt_reg  <= cnt_next;
        nj_reg   <= nj_next;
        mode_reg <= mode_next;
        val_reg  <= val_next;
        res_reg  <= res_next;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign res      = res_reg;

endmodule

[rtl/cllm_checker.sv]
// Port-level checks for the cursor linked list manager, bound to the top level.
module cllm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cllm_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int FOUND_LO = 1 + cllm_pkg::VALUE_W;

    logic [cllm_pkg::SLOT_W-1:0]  found;
    logic [cllm_pkg::VALUE_W-1:0] vout;

    assign found = m_tdata[FOUND_LO +: cllm_pkg::SLOT_W];
    assign vout  = m_tdata[1 +: cllm_pkg::VALUE_W];

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one request in flight: an accepted word drops ready
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    // errors never report a slot
    a_err_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> found == '0)
        else $error("error result carries a slot");

    // a found slot comes only from a successful find
    a_found_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && found != '0 |-> !m_tdata[0] && vout == '0)
        else $error("find result mixes in a deleted value");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind cursor_linked_list_manager cllm_checker u_cllm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb_cursor_linked_list_manager.sv]
// Self-checking testbench for cursor_linked_list_manager: directed and random list requests.
`timescale 1ns / 1ps

module tb_cursor_linked_list_manager;
    import cllm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam int RANDOM_ITEMS = 1850;
    localparam int LIMIT_CYCLES = 1_000_000;

    localparam result_t R_ERR = '{ST_ERR, 32'h0, NULL_SLOT};
    localparam result_t R_OK  = '{ST_OK, 32'h0, NULL_SLOT};

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        logic               typed;
        result_t            want;
    } step_t;

    // opening sequence; rows with typed = 0 are checked against the list model
    localparam step_t PLAN [25] = '{
        '{MODE_FIND,   6'd0,  32'h0000_0000, 1'b1, R_ERR},  // find on empty list
        '{MODE_DELETE, 6'd1,  32'h0000_0000, 1'b1, R_ERR},  // delete on empty list
        '{MODE_INSERT, 6'd0,  32'h1234_5678, 1'b1, R_ERR},  // position zero
        '{MODE_INSERT, 6'd2,  32'h0000_0000, 1'b1, R_ERR},  // past length + 1
        '{MODE_UNUSED, 6'd63, 32'hFFFF_FFFF, 1'b1, R_ERR},
        '{MODE_INSERT, 6'd1,  32'hFFFF_FFFF, 1'b1, R_OK},
        '{MODE_FIND,   6'd0,  32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 6'd1}},
        '{MODE_INSERT, 6'd2,  32'h0000_0000, 1'b1, R_OK},
        '{MODE_INSERT, 6'd1,  32'h8000_0000, 1'b1, R_OK},
        '{MODE_FIND,   6'd0,  32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 6'd2}},
        '{MODE_FIND,   6'd0,  32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 6'd3}},
        '{MODE_INSERT, 6'd63, 32'h0000_0001, 1'b1, R_ERR},
        '{MODE_DELETE, 6'd0,  32'h0000_0000, 1'b1, R_ERR},
        '{MODE_DELETE, 6'd4,  32'h0000_0000, 1'b1, R_ERR},
        '{MODE_INSERT, 6'd4,  32'h0000_0001, 1'b1, R_OK},   // append at length + 1
        '{MODE_DELETE, 6'd2,  32'h0000_0000, 1'b0, R_OK},
        '{MODE_INSERT, 6'd1,  32'hA5A5_A5A5, 1'b0, R_OK},   // reuses the freed slot
        '{MODE_FIND,   6'd0,  32'hA5A5_A5A5, 1'b0, R_OK},
        '{MODE_DELETE, 6'd63, 32'h0000_0000, 1'b1, R_ERR},
        '{MODE_DELETE, 6'd1,  32'h0000_0000, 1'b0, R_OK},
        '{MODE_DELETE, 6'd1,  32'h0000_0000, 1'b0, R_OK},
        '{MODE_DELETE, 6'd1,  32'h0000_0000, 1'b0, R_OK},
        '{MODE_DELETE, 6'd1,  32'h0000_0000, 1'b0, R_OK},
        '{MODE_DELETE, 6'd1,  32'h0000_0000, 1'b1, R_ERR},
        '{MODE_FIND,   6'd0,  32'h0000_0001, 1'b1, R_ERR}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // mode, position, value_in
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // status, value_out, slot_found

    cursor_linked_list_manager i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // list model state
    logic [SLOT_W-1:0]     next_slot [NODES];
    logic [DATA_WIDTH-1:0] slot_value [NODES];

    result_t replies_due [$];
    int      fails       = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;

    function automatic void rebuild_chains();
        for (int s = 0; s < NODES; s++) begin
            next_slot[s]  = (s < NODES - 2) ? SLOT_W'(s + 1) : NULL_SLOT;
            slot_value[s] = '0;
        end
    endfunction

    // slot of the node at list position p, head slot at position 0, 0 if past the end
    function automatic logic [SLOT_W-1:0] walk_to(input int p);
        logic [SLOT_W-1:0] k;
        k = HEAD_SLOT;
        for (int j = 0; j < p; j++) begin
            k = next_slot[k];
            if (k == NULL_SLOT) break;
        end
        return k;
    endfunction

    function automatic int list_length();
        logic [SLOT_W-1:0] k;
        int n;
        n = 0;
        k = next_slot[HEAD_SLOT];
        while (k != NULL_SLOT && n < NODES) begin
            n++;
            k = next_slot[k];
        end
        return n;
    endfunction

    function automatic result_t list_apply(input logic [MODE_W-1:0] mode,
                                           input logic [POS_W-1:0] pos,
                                           input logic [VALUE_W-1:0] v);
        result_t           r;
        logic [SLOT_W-1:0] j;
        logic [SLOT_W-1:0] k;
        r = R_ERR;
        case (mode)
            MODE_INSERT: begin
                if (pos != 0) begin
                    j = walk_to(int'(pos) - 1);
                    k = next_slot[0];
                    if (j != NULL_SLOT && k != NULL_SLOT) begin
                        next_slot[0] = next_slot[k];
                        slot_value[k] = v;
                        next_slot[k] = next_slot[j];
                        next_slot[j] = k;
                        r.status = ST_OK;
                    end
                end
            end
            MODE_DELETE: begin
                if (pos != 0) begin
                    j = walk_to(int'(pos) - 1);
                    k = (j != NULL_SLOT) ? next_slot[j] : NULL_SLOT;
                    if (k != NULL_SLOT) begin
                        r.value_out = slot_value[k];
                        next_slot[j] = next_slot[k];
                        next_slot[k] = next_slot[0];
                        next_slot[0] = k;
                        r.status = ST_OK;
                    end
                end
            end
            MODE_FIND: begin
                k = next_slot[HEAD_SLOT];
                for (int n = 0; n < NODES && k != NULL_SLOT; n++) begin
                    if (slot_value[k] == v) begin
                        r.slot_found = k;
                        r.status = ST_OK;
                        break;
                    end
                    k = next_slot[k];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // small pool makes duplicate values common, so find sees several matches
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return VALUE_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] stored_value(input int len);
        if (len == 0) return pick_value();
        return slot_value[walk_to($urandom_range(1, len))];
    endfunction

    // called at a falling edge; returns at the falling edge after the handshake
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                         input logic [VALUE_W-1:0] v, input logic typed,
                         input result_t want);
        result_t predicted;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tdata  <= {v, pos, mode};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = list_apply(mode, pos, v);
        replies_due.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // receiver: switches between always ready, coin flip and occasional long stalls
    int rx_style = 0;
    int rx_hold  = 0;
    int rx_stall = 0;

    always @(negedge aclk) begin
        if (rx_hold == 0) begin
            rx_style = $urandom_range(0, 2);
            rx_hold  = $urandom_range(50, 300);
        end else begin
            rx_hold--;
        end
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: begin
                if (rx_stall > 0) begin
                    rx_stall--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    rx_stall = $urandom_range(1, 12);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $error("result word with no request outstanding: %h", m_tdata);
                fails++;
            end else begin
                due = replies_due.pop_front();
                if (m_tdata[0] !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, m_tdata[0]);
                    fails++;
                end
                if (m_tdata[32:1] !== due.value_out) begin
                    $error("value_out: expected %h, got %h", due.value_out, m_tdata[32:1]);
                    fails++;
                end
                if (m_tdata[38:33] !== due.slot_found) begin
                    $error("slot_found: expected %0d, got %0d", due.slot_found, m_tdata[38:33]);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_cursor_linked_list_manager: FAIL");
            $finish;
        end
    end

    initial begin
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] v;
        int phase;
        int span;
        int len;
        int r;
        int sent;

        rebuild_chains();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (PLAN[i])
            issue(PLAN[i].mode, PLAN[i].pos, PLAN[i].value, PLAN[i].typed, PLAN[i].want);

        // phases: fill (runs into a full store), drain, mixed traffic, raw noise
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase = $urandom_range(0, 9);
            span  = (phase < 2) ? $urandom_range(70, 130) : $urandom_range(15, 80);
            for (int i = 0; i < span && sent < RANDOM_ITEMS; i++) begin
                len  = list_length();
                r    = $urandom_range(0, 19);
                v    = pick_value();
                mode = MODE_FIND;
                pos  = POS_W'($urandom_range(0, 63));
                if (phase < 2) begin
                    if (r < 17) begin
                        mode = MODE_INSERT;
                        pos  = POS_W'($urandom_range(1, len + 1));
                    end else if (r == 17) begin
                        mode = MODE_INSERT;
                        pos  = (len + 2 > 63) ? POS_W'(63) : POS_W'(len + 2);
                    end else begin
                        v = stored_value(len);
                    end
                end else if (phase < 4) begin
                    if (r < 17) begin
                        mode = MODE_DELETE;
                        pos  = POS_W'($urandom_range(1, (len == 0) ? 1 : len));
                    end else if (r == 17) begin
                        mode = MODE_DELETE;
                        pos  = POS_W'(len + 1);
                    end
                end else if (phase < 9) begin
                    if (r < 7) begin
                        mode = MODE_INSERT;
                        pos  = POS_W'($urandom_range(1, len + 1));
                    end else if (r < 13) begin
                        mode = MODE_DELETE;
                        pos  = POS_W'($urandom_range(1, (len == 0) ? 1 : len));
                    end else if (r < 19) begin
                        if (r < 17) v = stored_value(len);
                    end else begin
                        mode = ($urandom_range(0, 1) == 1) ? MODE_INSERT : MODE_DELETE;
                        pos  = '0;
                    end
                end else begin
                    mode = MODE_W'($urandom_range(0, 3));
                    v    = $urandom;
                end
                issue(mode, pos, v, 1'b0, R_OK);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (replies_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fails == 0) begin
            $display("tb_cursor_linked_list_manager: PASS");
        end else begin
            $display("tb_cursor_linked_list_manager: FAIL");
        end
        $finish;
    end

endmodule

[cursor_linked_list_manager.f]
rtl/cllm_pkg.sv
rtl/cllm_link_ram.sv
rtl/cllm_value_ram.sv
rtl/cllm_ctrl.sv
rtl/cursor_linked_list_manager.sv
rtl/cllm_checker.sv
tb/tb_cursor_linked_list_manager.sv
